// ===== rtl/rmsxt_pkg.sv =====
// Shared constants, payload types and controller state type for the xor trie block.
`default_nettype none

package rmsxt_pkg;

  localparam int VALUE_BITS = 31;
  localparam int NODE_COUNT = 65536;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int FREE_W = NODE_W + 1;
  localparam int LVL_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int LINK_W = 2 * NODE_W;

  // An insert needs up to VALUE_BITS fresh nodes; above this fill level it is skipped.
  localparam logic [FREE_W-1:0] FREE_LIMIT = FREE_W'(NODE_COUNT - VALUE_BITS);
  localparam logic [FREE_W-1:0] FREE_FULL  = FREE_W'(NODE_COUNT);
  localparam logic [LVL_W-1:0]  LVL_TOP    = LVL_W'(VALUE_BITS - 1);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  restart;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] best;
    logic                  overflow;
  } out_item_t;

  // One node word holds both child links: link 1 in the upper half, link 0 in the lower.
  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [LINK_W-1:0] wdata;
    logic [NODE_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INS_START,
    ST_INS_WALK,
    ST_INS_ALLOC,
    ST_QRY_START,
    ST_QRY_WALK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/rmsxt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module rmsxt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/rmsxt_ctrl.sv =====
// Trie walk sequencer: restart, maximum-xor query and prefix insert over the node memory.
`default_nettype none

module rmsxt_ctrl import rmsxt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  in_item_t          item,
  input  logic              slot_free,
  input  logic [LINK_W-1:0] rd_word,
  output mem_req_t          mem_req,
  output logic              idle,
  output logic              fin,
  output out_item_t         result
);

  state_t                  state, state_next;
  logic [VALUE_BITS-1:0]   rx;
  logic [VALUE_BITS-1:0]   best;
  logic                    ovf;
  logic                    primed;
  logic                    seed;
  logic [FREE_W-1:0]       next_free;
  logic [NODE_W-1:0]       cur;
  logic [LVL_W-1:0]        lvl;
  logic [VALUE_BITS-1:0]   qres;

  logic [VALUE_BITS-1:0]   ins_key;
  logic [LVL_W-1:0]        lvl_dn;
  logic                    kbit;
  logic                    qbit;
  logic [NODE_W-1:0]       link_lo;
  logic [NODE_W-1:0]       link_hi;
  logic [NODE_W-1:0]       link_b;
  logic [NODE_W-1:0]       q_opp;
  logic [NODE_W-1:0]       q_next;
  logic [VALUE_BITS-1:0]   qres_next;
  logic [NODE_W-1:0]       new_node;
  logic                    pool_short;
  state_t                  after_ins;

  // While seed is set, the insert is the empty prefix that a restart stores.
  assign ins_key    = seed ? '0 : rx;
  assign lvl_dn     = lvl - LVL_W'(1);
  assign kbit       = ins_key[lvl];
  assign qbit       = rx[lvl];
  assign link_lo    = rd_word[NODE_W-1:0];
  assign link_hi    = rd_word[LINK_W-1:NODE_W];
  assign link_b     = kbit ? link_hi : link_lo;
  assign q_opp      = qbit ? link_lo : link_hi;
  assign new_node   = next_free[NODE_W-1:0];
  assign pool_short = (next_free > FREE_LIMIT);
  assign after_ins  = seed ? ST_QRY_START : ST_DONE;

  always_comb begin
    qres_next      = qres;
    qres_next[lvl] = (q_opp != '0);
    q_next         = (q_opp != '0) ? q_opp : (qbit ? link_hi : link_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rx        <= '0;
      best      <= '0;
      ovf       <= 1'b0;
      primed    <= 1'b0;
      seed      <= 1'b0;
      next_free <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (item.restart || !primed) begin
              rx        <= item.value;
              best      <= '0;
              next_free <= FREE_W'(1);
              seed      <= 1'b1;
              primed    <= 1'b1;
            end else begin
              rx <= rx ^ item.value;
            end
          end
        end
        ST_INS_START: begin
          if (pool_short) begin
            ovf <= 1'b1;
          end
        end
        ST_INS_WALK: begin
          if (link_b == '0) begin
            next_free <= next_free + FREE_W'(1);
          end
        end
        ST_INS_ALLOC: begin
          if (lvl != '0) begin
            next_free <= next_free + FREE_W'(1);
          end
        end
        ST_QRY_START: begin
          seed <= 1'b0;
        end
        ST_QRY_WALK: begin
          if (lvl == '0 && qres_next > best) begin
            best <= qres_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Walk registers carry no reset; every walk loads them before use.
  always_ff @(posedge clk) begin
    case (state)
      ST_INS_START: begin
        lvl <= LVL_TOP;
        cur <= '0;
      end
      ST_INS_WALK: begin
        if (link_b != '0) begin
          cur <= link_b;
          lvl <= lvl_dn;
        end else begin
          cur <= new_node;
        end
      end
      ST_INS_ALLOC: begin
        if (lvl != '0) begin
          cur <= new_node;
          lvl <= lvl_dn;
        end
      end
      ST_QRY_START: begin
        lvl  <= LVL_TOP;
        qres <= '0;
      end
      ST_QRY_WALK: begin
        qres <= qres_next;
        lvl  <= lvl_dn;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    mem_req    = '0;
    fin        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (item.restart || !primed) ? ST_CLEAR : ST_QRY_START;
        end
      end
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = '0;
        mem_req.wdata = '0;
        state_next    = ST_INS_START;
      end
      ST_INS_START: begin
        mem_req.raddr = '0;
        state_next    = pool_short ? after_ins : ST_INS_WALK;
      end
      ST_INS_WALK: begin
        if (link_b != '0) begin
          mem_req.raddr = link_b;
          if (lvl == '0) begin
            state_next = after_ins;
          end
        end else begin
          // The first missing link: hang the new branch here, keep the sibling link.
          mem_req.we    = 1'b1;
          mem_req.waddr = cur;
          mem_req.wdata = kbit ? {new_node, link_lo} : {link_hi, new_node};
          state_next    = ST_INS_ALLOC;
        end
      end
      ST_INS_ALLOC: begin
        // Below the branch point every node is fresh; each write also empties the other link.
        mem_req.we    = 1'b1;
        mem_req.waddr = cur;
        if (lvl == '0) begin
          mem_req.wdata = '0;
          state_next    = after_ins;
        end else if (ins_key[lvl_dn]) begin
          mem_req.wdata = {new_node, {NODE_W{1'b0}}};
        end else begin
          mem_req.wdata = {{NODE_W{1'b0}}, new_node};
        end
      end
      ST_QRY_START: begin
        mem_req.raddr = '0;
        state_next    = ST_QRY_WALK;
      end
      ST_QRY_WALK: begin
        mem_req.raddr = q_next;
        if (lvl == '0) begin
          state_next = ST_INS_START;
        end
      end
      ST_DONE: begin
        fin = slot_free;
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign idle            = (state == ST_IDLE);
  assign result.best     = best;
  assign result.overflow = ovf;

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= FREE_FULL)
    else $error("node pool count ran past the pool size");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == ST_CLEAR || state == ST_INS_WALK || state == ST_INS_ALLOC))
    else $error("node memory written outside a clear or insert step");

  a_alloc_not_root: assert property (@(posedge clk) disable iff (rst)
    state == ST_INS_ALLOC |-> cur != '0)
    else $error("root node handed out as a fresh node");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    ovf |=> ovf)
    else $error("overflow flag cleared without reset");

  a_fin_to_idle: assert property (@(posedge clk) disable iff (rst)
    fin |=> state == ST_IDLE)
    else $error("result handed over but sequencer not idle");

endmodule

`default_nettype wire

// ===== rtl/running_max_subarray_xor_trie.sv =====
// Top level of the running maximum subarray xor block: handshakes, output register, node memory.
//
//   channel   direction   handshake                 payload
//   in        input       in_valid / in_ready       in_data  (in_item_t: value, restart)
//   out       output      out_valid / out_ready     out_data (out_item_t: best, overflow)
//
// Each item runs from its accepted transaction through a query walk and its start step,
// an insert walk and its start step, and a done step; the query walk takes one trie level
// per cycle through the memory's read port. A restart, and the first item after reset, add a
// clear of the root and a store of the zero prefix. An insert skipped for a nearly full pool
// has no walk.
// Reset clears the control state only; the node memory is not cleared and needs no sweep.
// The next item is taken while a finished result waits in the output register; a walk
// finishing into a full output register stalls until out_ready frees it.
`default_nettype none

module running_max_subarray_xor_trie import rmsxt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  mem_req_t          mem_req;
  logic [LINK_W-1:0] rd_word;
  logic              idle;
  logic              fin;
  logic              slot_free;
  out_item_t         result;

  assign in_ready  = idle;
  assign slot_free = !out_valid || out_ready;

  rmsxt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .item      (in_data),
    .slot_free (slot_free),
    .rd_word   (rd_word),
    .mem_req   (mem_req),
    .idle      (idle),
    .fin       (fin),
    .result    (result)
  );

  rmsxt_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NODE_COUNT)
  ) u_nodes (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the running maximum subarray xor trie block.
`timescale 1ns / 1ps

module tb;
  import rmsxt_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  running_max_subarray_xor_trie i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic                  restart;
    bit                    typed;
    logic [VALUE_BITS-1:0] best;
  } script_row_t;

  // Shadow copy of the trie and the running values of the block.
  int                    link_mem [0:2*NODE_COUNT-1];
  int                    nodes_used    = 0;
  logic [VALUE_BITS-1:0] prefix_acc    = '0;
  logic [VALUE_BITS-1:0] best_acc      = '0;
  logic                  pool_overflow = 1'b0;
  logic                  trie_live     = 1'b0;

  out_item_t   pending_results[$];
  script_row_t script[$];
  int          mismatch_count = 0;
  int          sent           = 0;
  int          received       = 0;
  bit          send_burst     = 1'b0;
  bit          recv_burst     = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void trie_store(input logic [VALUE_BITS-1:0] key);
    int node;
    int nxt;
    int lvl;
    if (NODE_COUNT - nodes_used < VALUE_BITS) begin
      pool_overflow = 1'b1;
      return;
    end
    node = 0;
    for (lvl = VALUE_BITS - 1; lvl >= 0; lvl--) begin
      nxt = link_mem[2*node + int'(key[lvl])];
      if (nxt == 0) begin
        nxt = nodes_used;
        nodes_used++;
        link_mem[2*nxt]     = 0;
        link_mem[2*nxt + 1] = 0;
        link_mem[2*node + int'(key[lvl])] = nxt;
      end
      node = nxt;
    end
  endfunction

  // Greedy walk: take the branch opposite to the key bit whenever it exists.
  function automatic logic [VALUE_BITS-1:0] widest_xor(input logic [VALUE_BITS-1:0] key);
    int                    node;
    int                    other;
    int                    lvl;
    logic [VALUE_BITS-1:0] res;
    node = 0;
    res  = '0;
    for (lvl = VALUE_BITS - 1; lvl >= 0; lvl--) begin
      other = link_mem[2*node + int'(!key[lvl])];
      if (other != 0) begin
        node     = other;
        res[lvl] = 1'b1;
      end else begin
        node = link_mem[2*node + int'(key[lvl])];
      end
    end
    return res;
  endfunction

  function automatic out_item_t next_best(input in_item_t item);
    out_item_t             res;
    logic [VALUE_BITS-1:0] q;
    if (item.restart || !trie_live) begin
      link_mem[0] = 0;
      link_mem[1] = 0;
      nodes_used  = 1;
      prefix_acc  = '0;
      best_acc    = '0;
      trie_store('0);
      trie_live   = 1'b1;
    end
    prefix_acc = prefix_acc ^ item.value;
    q = widest_xor(prefix_acc);
    if (q > best_acc) begin
      best_acc = q;
    end
    trie_store(prefix_acc);
    res.best     = best_acc;
    res.overflow = pool_overflow;
    return res;
  endfunction

  function automatic void add_row(input logic [VALUE_BITS-1:0] v, input logic r,
                                  input bit typed, input logic [VALUE_BITS-1:0] b);
    script_row_t row;
    row.value   = v;
    row.restart = r;
    row.typed   = typed;
    row.best    = b;
    script.push_back(row);
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return VALUE_BITS'($urandom_range(0, 15));
      3: return VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1);
      default: return VALUE_BITS'($urandom());
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic feed(input logic [VALUE_BITS-1:0] v, input logic r, input bit typed,
                      input logic [VALUE_BITS-1:0] typed_best);
    in_item_t  item;
    out_item_t want;
    int        gap;
    item.value   = v;
    item.restart = r;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    want = next_best(item);
    if (typed) begin
      want.best     = typed_best;
      want.overflow = 1'b0;
    end
    pending_results.push_back(want);
    sent++;
    if (sent % 60 == 0) begin
      send_burst = ($urandom_range(0, 3) == 0);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;

    // A restart is pending after reset, so the first item starts from an empty trie.
    add_row(31'h00000000, 1'b0, 1'b1, 31'h00000000);
    add_row(31'h7FFFFFFF, 1'b0, 1'b1, 31'h7FFFFFFF);
    add_row(31'h7FFFFFFF, 1'b0, 1'b1, 31'h7FFFFFFF);
    add_row(31'h00000000, 1'b1, 1'b1, 31'h00000000);
    add_row(31'h7FFFFFFF, 1'b1, 1'b1, 31'h7FFFFFFF);
    add_row(31'h00000001, 1'b1, 1'b1, 31'h00000001);
    add_row(31'h40000000, 1'b0, 1'b0, '0);
    add_row(31'h2AAAAAAA, 1'b0, 1'b0, '0);
    add_row(31'h55555555, 1'b0, 1'b0, '0);
    add_row(31'h00000000, 1'b0, 1'b0, '0);
    add_row(31'h00000000, 1'b1, 1'b1, 31'h00000000);
    add_row(31'h00000000, 1'b0, 1'b1, 31'h00000000);
    add_row(31'h12345678, 1'b1, 1'b1, 31'h12345678);
    add_row(31'h7FFFFFFE, 1'b0, 1'b0, '0);
    add_row(31'h00000001, 1'b0, 1'b0, '0);
    add_row(31'h40000000, 1'b1, 1'b1, 31'h40000000);
    add_row(31'h3FFFFFFF, 1'b0, 1'b1, 31'h7FFFFFFF);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      feed(script[i].value, script[i].restart, script[i].typed, script[i].best);
    end

    for (int n = 0; n < 900; n++) begin
      if (n % 150 == 149) begin
        wait_drained();
      end
      feed(pick_value(), ($urandom_range(0, 39) == 0), 1'b0, '0);
    end

    // After a long run, restart from a drained block and keep going with some restarts.
    wait_drained();
    feed(pick_value(), 1'b1, 1'b0, '0);
    repeat (20) feed(pick_value(), ($urandom_range(0, 9) == 0), 1'b0, '0);

    wait_drained();
    repeat (120) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int        stall;
    out_item_t want;
    @(negedge rst);
    forever begin
      stall = recv_burst ? 0 : $urandom_range(0, 10);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        do @(posedge clk); while (!out_valid);
        repeat (stall) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      do @(posedge clk); while (!out_valid);
      received++;
      if (received % 50 == 0) begin
        recv_burst = ($urandom_range(0, 3) == 0);
      end
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: best %h, overflow %b", out_data.best, out_data.overflow);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.best !== want.best) begin
          $error("best: expected %h, got %h", want.best, out_data.best);
          mismatch_count++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow: expected %b, got %b", want.overflow, out_data.overflow);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
